// ----- rtl/page_allocator_best_worst_fit_top_defines.svh -----
// Assertion macros for the page allocator.
// Define NO_ASSERTIONS to compile them out.
`ifndef PAGE_ALLOCATOR_BEST_WORST_FIT_TOP_DEFINES_SVH
`define PAGE_ALLOCATOR_BEST_WORST_FIT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PABWF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define PABWF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PABWF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PABWF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/pabwf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pabwf_pkg;

  localparam int NUM_PAGES  = 32;
  localparam int PAGE_KB    = 4;
  localparam int OWNER_BITS = 8;

  localparam int PAGE_W = $clog2(NUM_PAGES);      // page index
  localparam int PTR_W  = $clog2(NUM_PAGES + 1);  // index plus end marker
  localparam int CNT_W  = PTR_W;                  // page counts 0..NUM_PAGES
  localparam int FRAG_W = 5;
  localparam int NEED_W = 16;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_COUNT   = 2'd2,
    OP_RSVD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADREQ   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [OWNER_BITS-1:0] program_id;
    logic [15:0]           size_kb;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] start_page;
    logic [CNT_W-1:0]  page_count;
    logic [FRAG_W-1:0] fragment_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request
    logic start;   // clear pointer and accumulators
    logic scan;    // one step of the free-run search
    logic rewind;  // pointer back to page 0
    logic update;  // one step of the write / count pass
    logic emit;    // write the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic alloc_go;   // allocate request that needs a search
    logic scan_last;  // search has passed the last page
    logic upd_last;   // update pass is at the last page
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/page_allocator_best_worst_fit_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Contiguous page allocator for a 32-page map, 4 KB pages, 8-bit owner ids
// (0 = free). Allocate rounds size_kb up to whole pages and places the run in
// the largest (fit_mode 0, worst fit) or smallest (fit_mode 1, best fit) free
// run that is long enough, lowest address on ties; release frees every page
// of an owner; count only reports. Every request gives one result
// transaction carrying the number of free runs left in the map. One request
// is in flight at a time: release, count and rejected requests go through
// decode, the update pass and finish; an allocate that searches first runs a
// search (one 33-step pass over the map to find the run, then one 32-step
// pass that writes the owner and counts free runs, both one page per cycle).
// The map is cleared by reset. fit_mode may only be written while no request
// is outstanding; its port is always ready.

module page_allocator_best_worst_fit_top (
  input  logic             clk,
  input  logic             rst,
  // configuration: fit_mode
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  // request
  input  logic             in_valid,
  output logic             in_ready,
  input  pabwf_pkg::req_t  in_data,
  // result
  output logic             out_valid,
  input  logic             out_ready,
  output pabwf_pkg::rsp_t  out_data
);
  import pabwf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register write has no side effects; take it whenever offered
  assign cfg_ready = 1'b1;

  // sequencer: accept, search, update pass, hand result to output register
  pabwf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // page map, run search, fragment counter and result register
  pabwf_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_bit (cfg_data),
    .req_in  (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .rsp     (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/pabwf_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pabwf_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_bit,
  input  pabwf_pkg::req_t  req_in,
  input  pabwf_pkg::cmd_t  cmd,
  output pabwf_pkg::sts_t  sts,
  output pabwf_pkg::rsp_t  rsp
);
  import pabwf_pkg::*;

  logic                  fit_mode;
  logic [1:0]            op_q;
  logic [OWNER_BITS-1:0] id_q;
  logic [NEED_W-1:0]     need_q;
  logic [OWNER_BITS-1:0] owner [NUM_PAGES];

  logic [PTR_W-1:0]  ptr;
  logic [CNT_W-1:0]  run_len;
  logic [PAGE_W-1:0] run_start;
  logic              found;
  logic [CNT_W-1:0]  best_len;
  logic [PAGE_W-1:0] best_start;
  logic              prev_free;
  logic [FRAG_W-1:0] frag;
  logic [CNT_W-1:0]  rel_cnt;

  logic [NEED_W-1:0]     need_in;
  logic                  id_nz, need_nz, fits, alloc_go, rel_go;
  logic [CNT_W-1:0]      need_c;
  logic [PAGE_W-1:0]     idx;
  logic                  ptr_end;
  logic [OWNER_BITS-1:0] owner_rd;
  logic                  scan_free, better, take;
  logic [CNT_W:0]        end_sum;
  logic                  in_run, wr_alloc, rel_hit, new_free;
  logic [OWNER_BITS-1:0] new_owner;
  rsp_t                  rsp_next;

  // pages needed, rounded up
  assign need_in = NEED_W'(req_in.size_kb / PAGE_KB)
                 + NEED_W'((req_in.size_kb % PAGE_KB) != 0);

  assign id_nz    = id_q != '0;
  assign need_nz  = need_q != '0;
  assign fits     = need_q <= NEED_W'(NUM_PAGES);
  assign alloc_go = (op_q == OP_ALLOC) && id_nz && need_nz && fits;
  assign rel_go   = (op_q == OP_RELEASE) && id_nz;
  assign need_c   = need_q[CNT_W-1:0];

  assign idx      = ptr[PAGE_W-1:0];
  assign ptr_end  = ptr == PTR_W'(NUM_PAGES);
  assign owner_rd = owner[idx];

  // search: a run closes on a used page or at the end of the map
  assign scan_free = !ptr_end && (owner_rd == '0);
  assign better    = fit_mode ? (run_len < best_len) : (run_len > best_len);
  assign take      = !scan_free && (run_len >= need_c) && (!found || better);

  // update pass
  assign end_sum   = (CNT_W+1)'(best_start) + (CNT_W+1)'(need_c);
  assign in_run    = found && (idx >= best_start) && ((CNT_W+1)'(idx) < end_sum);
  assign wr_alloc  = alloc_go && in_run;
  assign rel_hit   = rel_go && (owner_rd == id_q);
  assign new_owner = wr_alloc ? id_q : (rel_hit ? '0 : owner_rd);
  assign new_free  = new_owner == '0;

  assign sts.alloc_go  = alloc_go;
  assign sts.scan_last = ptr_end;
  assign sts.upd_last  = ptr == PTR_W'(NUM_PAGES - 1);

  always_comb begin
    rsp_next                = '0;
    rsp_next.fragment_count = frag;
    case (op_q)
      OP_ALLOC: begin
        if (!id_nz || !need_nz) begin
          rsp_next.status = ST_BADREQ;
        end else if (!fits || !found) begin
          rsp_next.status = ST_NOMEM;
        end else begin
          rsp_next.status     = ST_OK;
          rsp_next.start_page = best_start;
          rsp_next.page_count = need_c;
        end
      end
      OP_RELEASE: begin
        if (!id_nz) begin
          rsp_next.status = ST_BADREQ;
        end else if (rel_cnt == '0) begin
          rsp_next.status = ST_NOTFOUND;
        end else begin
          rsp_next.status     = ST_OK;
          rsp_next.page_count = rel_cnt;
        end
      end
      OP_COUNT: rsp_next.status = ST_OK;
      default:  rsp_next.status = ST_BADREQ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= 1'b0;
    end else if (cfg_we) begin
      fit_mode <= cfg_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        owner[i] <= '0;
      end
    end else if (cmd.update && (wr_alloc || rel_hit)) begin
      owner[idx] <= new_owner;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= req_in.operation;
      id_q   <= req_in.program_id;
      need_q <= need_in;
    end
    if (cmd.start) begin
      run_len    <= '0;
      run_start  <= '0;
      found      <= 1'b0;
      best_len   <= '0;
      best_start <= '0;
      prev_free  <= 1'b0;
      frag       <= '0;
      rel_cnt    <= '0;
    end
    if (cmd.scan) begin
      if (scan_free) begin
        if (run_len == '0) begin
          run_start <= idx;
        end
        run_len <= run_len + 1'b1;
      end else begin
        if (take) begin
          found      <= 1'b1;
          best_len   <= run_len;
          best_start <= run_start;
        end
        run_len <= '0;
      end
    end
    if (cmd.update) begin
      prev_free <= new_free;
      if (new_free && !prev_free) begin
        frag <= frag + 1'b1;
      end
      if (rel_hit) begin
        rel_cnt <= rel_cnt + 1'b1;
      end
    end
    if (cmd.emit) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (cmd.start || cmd.rewind) begin
      ptr <= '0;
    end else if (cmd.scan || cmd.update) begin
      ptr <= ptr + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pabwf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "page_allocator_best_worst_fit_top_defines.svh"

module pabwf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  pabwf_pkg::sts_t  sts,
  output pabwf_pkg::cmd_t  cmd
);
  import pabwf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.start  = 1'b1;
        state_next = sts.alloc_go ? S_SCAN : S_UPDATE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          cmd.rewind = 1'b1;
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.upd_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PABWF_ASSERT_IMP(a_emit_slot_free, clk, rst, cmd.emit, out_free, "result overwrites pending one")
  `PABWF_ASSERT_NXT(a_accept_blocks, clk, rst, in_valid && in_ready, !in_ready, "second request taken")
  `PABWF_ASSERT_NXT(a_scan_to_update, clk, rst, (state == S_SCAN) && sts.scan_last, state == S_UPDATE, "search did not hand over")

endmodule

`default_nettype wire

// ----- test/page_allocator_best_worst_fit_top_tb.sv -----
`timescale 1ns / 1ps

module page_allocator_best_worst_fit_top_tb;
  import pabwf_pkg::*;

  // Generous ceiling: roughly 530 requests, plus sender gaps and receiver
  // stalls, several times over.
  localparam int CYCLE_LIMIT = 500000;
  // Worst-case request latency (allocate with search) plus a margin.
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_GAP = 90;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  // Shadow copy of the page map and the placement policy.
  logic [OWNER_BITS-1:0] page_map [NUM_PAGES];
  bit best_fit_sel = 1'b0;

  // Results predicted at request acceptance, oldest first.
  rsp_t pending_results [$];

  // Handshake pressure, in percent, changed between phases.
  int idle_pct = 0;
  int stall_pct = 0;

  int errors = 0;
  int cycle_count = 0;
  int n_requests = 0;
  int n_placed = 0;
  int n_no_room = 0;
  int n_malformed = 0;
  int n_results = 0;

  page_allocator_best_worst_fit_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake must not hang the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Number of maximal free runs in the shadow map.
  function automatic int count_free_runs();
    int runs;
    bit prev_free;
    runs = 0;
    prev_free = 1'b0;
    for (int p = 0; p < NUM_PAGES; p++) begin
      if (page_map[p] == '0 && !prev_free) runs++;
      prev_free = (page_map[p] == '0);
    end
    return runs;
  endfunction

  // Applies one request to the shadow map and returns the result it gives.
  function automatic rsp_t predict_request(req_t r);
    rsp_t res;
    status_t st;
    logic [OWNER_BITS-1:0] id;
    int kb, need, start, cnt, p, s, len, best_len;
    bit found;
    id = r.program_id;
    kb = r.size_kb;
    st = ST_OK;
    start = 0;
    cnt = 0;
    case (op_t'(r.operation))
      OP_ALLOC: begin
        // Round up to whole pages.
        need = kb / PAGE_KB + ((kb % PAGE_KB) != 0);
        if (id == '0 || need == 0) begin
          st = ST_BADREQ;
        end else if (need > NUM_PAGES) begin
          st = ST_NOMEM;
        end else begin
          found = 1'b0;
          best_len = 0;
          p = 0;
          while (p < NUM_PAGES) begin
            if (page_map[p] != '0) begin
              p++;
            end else begin
              s = p;
              while (p < NUM_PAGES && page_map[p] == '0) p++;
              len = p - s;
              // Strict compare keeps the lowest run on ties.
              if (len >= need && (!found ||
                  (best_fit_sel ? (len < best_len) : (len > best_len)))) begin
                found = 1'b1;
                best_len = len;
                start = s;
              end
            end
          end
          if (!found) begin
            st = ST_NOMEM;
            start = 0;
          end else begin
            for (int i = 0; i < need; i++) page_map[start + i] = id;
            cnt = need;
          end
        end
      end
      OP_RELEASE: begin
        if (id == '0) begin
          st = ST_BADREQ;
        end else begin
          for (int q = 0; q < NUM_PAGES; q++) begin
            if (page_map[q] == id) begin
              page_map[q] = '0;
              cnt++;
            end
          end
          if (cnt == 0) st = ST_NOTFOUND;
        end
      end
      OP_COUNT: ;
      default: st = ST_BADREQ;
    endcase
    res.status = st;
    res.start_page = PAGE_W'(start);
    res.page_count = CNT_W'(cnt);
    res.fragment_count = FRAG_W'(count_free_runs());
    return res;
  endfunction

  function automatic req_t make_request(op_t op, logic [OWNER_BITS-1:0] id,
                                        logic [15:0] kb);
    req_t r;
    r.operation = op;
    r.program_id = id;
    r.size_kb = kb;
    return r;
  endfunction

  // Random traffic: mostly allocate/release from a small owner pool so the map
  // fills, fragments and drains; the remainder is counts and malformed items.
  function automatic req_t random_request();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    r.size_kb = 16'($urandom);
    if ($urandom_range(9) == 0) r.program_id = OWNER_BITS'($urandom_range(255));
    else r.program_id = OWNER_BITS'($urandom_range(12, 1));
    if (pick < 52) begin
      r.operation = OP_ALLOC;
      case ($urandom_range(9))
        0: r.size_kb = 16'($urandom_range(65535));
        1, 2: r.size_kb = 16'($urandom_range(NUM_PAGES * PAGE_KB, 1));
        default: r.size_kb = 16'($urandom_range(40, 1));
      endcase
    end else if (pick < 86) begin
      r.operation = OP_RELEASE;
    end else if (pick < 93) begin
      r.operation = OP_COUNT;
    end else begin
      case ($urandom_range(3))
        0: r.operation = OP_RSVD;
        1: begin
          r.operation = OP_ALLOC;
          r.program_id = '0;
        end
        2: begin
          r.operation = OP_ALLOC;
          r.size_kb = '0;
        end
        default: begin
          r.operation = OP_RELEASE;
          r.program_id = '0;
        end
      endcase
    end
    return r;
  endfunction

  // Sends one request, with an optional idle gap first. Valid is left high
  // after acceptance; the next call or a drain decides whether it drops.
  task automatic issue_request(input req_t r);
    rsp_t want;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    want = predict_request(r);
    pending_results.push_back(want);
    n_requests++;
    if (want.status == ST_OK && r.operation == OP_ALLOC) n_placed++;
    if (want.status == ST_NOMEM) n_no_room++;
    if (want.status == ST_BADREQ) n_malformed++;
  endtask

  // Every request yields a result, so an empty queue means the block is idle;
  // a few extra cycles cover the return to the idle state.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fit_mode(input bit mode);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    best_fit_sel = mode;
  endtask

  // Receiver: random back-pressure plus the result scoreboard.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
      end else begin
        automatic rsp_t want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.start_page !== want.start_page) begin
          $error("start_page: expected %0d, got %0d", want.start_page,
                 out_data.start_page);
          errors++;
        end
        if (out_data.page_count !== want.page_count) begin
          $error("page_count: expected %0d, got %0d", want.page_count,
                 out_data.page_count);
          errors++;
        end
        if (out_data.fragment_count !== want.fragment_count) begin
          $error("fragment_count: expected %0d, got %0d", want.fragment_count,
                 out_data.fragment_count);
          errors++;
        end
      end
    end
  end

  // Field extremes, every opcode and the malformed cases, starting from the
  // cleared map in worst-fit mode. Leaves the map empty.
  task automatic test_basic_requests();
    write_fit_mode(1'b0);
    issue_request(make_request(OP_COUNT, 8'd0, 16'd0));
    issue_request(make_request(OP_RSVD, 8'hFF, 16'hFFFF));
    issue_request(make_request(OP_ALLOC, 8'd5, 16'd0));       // zero pages
    issue_request(make_request(OP_ALLOC, 8'd0, 16'd8));       // null owner
    issue_request(make_request(OP_RELEASE, 8'd0, 16'd0));     // null owner
    issue_request(make_request(OP_RELEASE, 8'd77, 16'd0));    // owner holds nothing
    issue_request(make_request(OP_ALLOC, 8'd9, 16'd129));     // one page over the map
    issue_request(make_request(OP_ALLOC, 8'hFF, 16'hFFFF));   // far over the map
    issue_request(make_request(OP_ALLOC, 8'hFF, 16'd128));    // whole map
    issue_request(make_request(OP_COUNT, 8'h00, 16'h0000));
    issue_request(make_request(OP_ALLOC, 8'd3, 16'd1));       // map full
    issue_request(make_request(OP_RELEASE, 8'hFF, 16'd0));
    issue_request(make_request(OP_ALLOC, 8'hAA, 16'd1));      // rounds up to 1 page
    issue_request(make_request(OP_ALLOC, 8'h55, 16'd5));      // rounds up to 2 pages
    issue_request(make_request(OP_ALLOC, 8'hAA, 16'd4));      // exact page
    issue_request(make_request(OP_RELEASE, 8'hAA, 16'd0));    // two separate pages
    issue_request(make_request(OP_RELEASE, 8'h55, 16'hFFFF));
  endtask

  // Builds free runs of 4, 8 and 4 pages, then places into them under each
  // policy: worst fit takes the 8-run, best fit the first 4-run on the tie.
  task automatic test_fit_policies();
    issue_request(make_request(OP_ALLOC, 8'd1, 16'd16));
    issue_request(make_request(OP_ALLOC, 8'd2, 16'd16));
    issue_request(make_request(OP_ALLOC, 8'd3, 16'd16));
    issue_request(make_request(OP_ALLOC, 8'd4, 16'd32));
    issue_request(make_request(OP_ALLOC, 8'd5, 16'd16));
    issue_request(make_request(OP_ALLOC, 8'd6, 16'd16));
    issue_request(make_request(OP_RELEASE, 8'd2, 16'd0));
    issue_request(make_request(OP_RELEASE, 8'd4, 16'd0));
    issue_request(make_request(OP_ALLOC, 8'd9, 16'd8));
    write_fit_mode(1'b1);
    issue_request(make_request(OP_ALLOC, 8'd10, 16'd8));
    issue_request(make_request(OP_ALLOC, 8'd11, 16'd20));     // only the 6-run fits
    issue_request(make_request(OP_ALLOC, 8'd12, 16'd36));     // no 9-page run
    issue_request(make_request(OP_COUNT, 8'd0, 16'd0));
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input bit mode,
                                     input int n_items);
    write_fit_mode(mode);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) issue_request(random_request());
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_basic_requests();
    test_fit_policies();
    // Pressure phases: none, sender gaps, receiver stalls, both lightly.
    test_random_traffic(0, 0, 1'b1, 125);
    test_random_traffic(51, 0, 1'b0, 125);
    test_random_traffic(0, 51, 1'b1, 125);
    test_random_traffic(6, 6, 1'($urandom_range(1)), 125);

    // Catch any stray result after the last expected one.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end

    $display("Ran %0d requests, %0d results: %0d placements, %0d refused for space,",
             n_requests, n_results, n_placed, n_no_room);
    $display("%0d malformed, across both fit policies and four back-pressure mixes.",
             n_malformed);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
